FILE: src/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types and constants for the FIFO queue with positional discard.
// ----------------------------------------------------------------------------
package fqd_pkg;

  // Queue depth; must be a power of two so physical addresses wrap for free
  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;
  localparam int PW    = 4;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ENQ = 2'd0,
    REQ_DEQ = 2'd1,
    REQ_DIS = 2'd2,
    REQ_NOP = 2'd3
  } req_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FRONT,
    ST_RESP
  } state_e;

  // RAM access from the sequencer
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
  } ram_req_t;

  // One result transaction
  typedef struct packed {
    logic          error;
    logic          is_empty;
    logic [CW-1:0] count;
    logic [DW-1:0] front_value;
  } res_t;

endpackage

FILE: src/fqd_ram.sv
// ----------------------------------------------------------------------------
// fqd_ram
// Element storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fqd_ram
  import fqd_pkg::*;
(
  input  logic          clk_i,
  input  ram_req_t      req_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/fqd_ctrl.sv
// ----------------------------------------------------------------------------
// fqd_ctrl
// Request sequencer: ring head pointer, count and the gap-closing shift loop.
// ----------------------------------------------------------------------------
module fqd_ctrl
  import fqd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  logic [1:0]    req_type_i,
  input  logic [DW-1:0] value_i,
  input  logic [PW-1:0] position_i,
  output ram_req_t      ram_req_o,
  input  logic [DW-1:0] ram_rdata_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output res_t          res_o
);

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          err_q, err_d;

  logic [CW-1:0] pos_ext;
  logic          dis_in_range;
  logic          dis_shift;
  logic          more_shift;
  req_e          req;

  assign req          = req_e'(req_type_i);
  assign pos_ext      = CW'(position_i);
  assign dis_in_range = pos_ext < cnt_q;
  // Discard of an inner element needs the shift loop
  assign dis_shift    = dis_in_range && (pos_ext != '0) && ((pos_ext + CW'(1)) != cnt_q);
  // Another element still sits behind the current gap
  assign more_shift   = (CW'(idx_q) + CW'(2)) < cnt_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = (req == REQ_DIS && dis_shift) ? ST_SHIFT_RD : ST_FRONT;
        end
      end
      ST_SHIFT_RD: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: state_d = more_shift ? ST_SHIFT_RD : ST_FRONT;
      ST_FRONT:    state_d = ST_RESP;
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    ram_req_o       = '0;
    ram_req_o.raddr = head_q;
    head_d          = head_q;
    cnt_d           = cnt_q;
    idx_d           = idx_q;
    err_d           = err_q;
    req_ready_o     = 1'b0;
    res_valid_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          err_d = 1'b0;
          case (req)
            REQ_ENQ: begin
              if (cnt_q == CW'(DEPTH)) begin
                err_d = 1'b1;
              end else begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = head_q + cnt_q[AW-1:0];
                ram_req_o.wdata = value_i;
                cnt_d           = cnt_q + CW'(1);
              end
            end
            REQ_DEQ: begin
              if (cnt_q == '0) begin
                err_d = 1'b1;
              end else begin
                head_d = head_q + AW'(1);
                cnt_d  = cnt_q - CW'(1);
              end
            end
            REQ_DIS: begin
              if (dis_in_range) begin
                if (pos_ext == '0) begin
                  head_d = head_q + AW'(1);
                  cnt_d  = cnt_q - CW'(1);
                end else if (!dis_shift) begin
                  // last element: just drop it
                  cnt_d = cnt_q - CW'(1);
                end else begin
                  idx_d = AW'(position_i);
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT_RD: begin
        ram_req_o.raddr = head_q + idx_q + AW'(1);
      end
      ST_SHIFT_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = head_q + idx_q;
        ram_req_o.wdata = ram_rdata_i;
        idx_d           = idx_q + AW'(1);
        if (!more_shift) begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      ST_FRONT: ;
      ST_RESP: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Result fields
  always_comb begin
    res_o.error       = err_q;
    res_o.is_empty    = (cnt_q == '0);
    res_o.count       = cnt_q;
    res_o.front_value = (cnt_q == '0) ? '0 : ram_rdata_i;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  // Shift index
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

endmodule

FILE: src/fifo_queue_with_positional_discard.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_positional_discard
// Ordered queue of signed 32-bit elements with enqueue, dequeue and
// discard at a position; every transaction returns front, count and flags.
//
//   channel | dir | tdata fields (low bit first)
//   s_axis  | in  | req_type[1:0], value[33:2], position[37:34], zero pad
//   m_axis  | out | front_value[31:0], count[36:32], is_empty[37],
//           |     | error[38], zero pad
//
// Enqueue, dequeue, out-of-range discard and discard of the front or last
// element go through the idle, front and result states; an inner discard at
// position p with count n first shifts the n-1-p elements behind it, one
// RAM read and one RAM write each, through the single-port-pair storage.
// One request is in work at a time; the next is taken once the result sits
// in the output register. Reset clears state, count, head, error, out valid.
// ----------------------------------------------------------------------------
module fifo_queue_with_positional_discard
  import fqd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // req_type, value, position
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // front_value, count, is_empty, error
);

  ram_req_t      ram_req;
  logic [DW-1:0] ram_rdata;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          out_valid_q;
  res_t          out_q;

  fqd_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  fqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_type_i  (s_axis_tdata[1:0]),
    .value_i     (s_axis_tdata[33:2]),
    .position_i  (s_axis_tdata[37:34]),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[36:32] <= 5'(DEPTH)))
    else $error("count above depth");
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[37] == (m_axis_tdata[36:32] == '0)))
    else $error("empty flag disagrees with count");
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[37]) |-> (m_axis_tdata[31:0] == '0))
    else $error("front not zero when empty");
  a_error_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[38]) |->
      (m_axis_tdata[36:32] == '0 || m_axis_tdata[36:32] == 5'(DEPTH)))
    else $error("error flagged while neither empty nor full");
`endif

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO queue with positional discard. Requests
// go in on the slave stream and results come back on the master stream. A
// shadow queue predicts every result, and a scoreboard compares the results
// field by field.
// ----------------------------------------------------------------------------
module tb
  import fqd_pkg::*;
();

  typedef struct {
    logic [DW-1:0] front;
    logic [4:0]    cnt;
    logic          empty;
    logic          err;
  } qres_t;

  // Shadow queue plus the store of expected results
  class queue_scoreboard;
    logic [DW-1:0] shadow[$];
    qres_t         pending[$];
    int            n_fail;
    int            n_checked;
    int            n_discard;
    int            n_err;

    function void note_request(req_e kind, logic [DW-1:0] val, logic [PW-1:0] pos);
      qres_t r;
      r.err = 1'b0;
      case (kind)
        REQ_ENQ: begin
          if (shadow.size() >= DEPTH) r.err = 1'b1;
          else shadow.push_back(val);
        end
        REQ_DEQ: begin
          if (shadow.size() == 0) r.err = 1'b1;
          else void'(shadow.pop_front());
        end
        REQ_DIS: begin
          if (pos < shadow.size()) begin
            shadow.delete(pos);
            n_discard++;
          end
        end
        default: ;
      endcase
      if (r.err) n_err++;
      r.front = (shadow.size() > 0) ? shadow[0] : '0;
      r.cnt   = 5'(shadow.size());
      r.empty = (shadow.size() == 0);
      pending.push_back(r);
    endfunction

    function void check_result(logic [39:0] d);
      qres_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, d);
        n_fail++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (d[31:0] !== e.front) begin
        $display("%0t: front_value exp %h got %h", $time, e.front, d[31:0]);
        n_fail++;
      end
      if (d[36:32] !== e.cnt) begin
        $display("%0t: count exp %0d got %0d", $time, e.cnt, d[36:32]);
        n_fail++;
      end
      if (d[37] !== e.empty) begin
        $display("%0t: is_empty exp %b got %b", $time, e.empty, d[37]);
        n_fail++;
      end
      if (d[38] !== e.err) begin
        $display("%0t: error exp %b got %b", $time, e.err, d[38]);
        n_fail++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  queue_scoreboard sb = new();
  longint cycles = 0;
  bit     stim_done = 1'b0;

  fifo_queue_with_positional_discard u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit: the run fails if the cycle counter passes its bound
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Accepted transactions on both sides
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_request(req_e'(s_axis_tdata[1:0]), s_axis_tdata[33:2],
                      s_axis_tdata[37:34]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  // Result side stalls at random, with calm stretches
  initial begin
    int w;
    int mode;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      mode = $urandom_range(0, 3);
      w = (mode == 0) ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // One request, with a given gap before it
  task automatic send_req(req_e kind, logic [DW-1:0] val, logic [PW-1:0] pos,
                          int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {2'b00, pos, val, kind};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_rand(req_e kind, int bias);
    int g;
    int p;
    logic [DW-1:0] v;
    g = (bias == 0) ? 0 : $urandom_range(0, 10);
    v = $urandom();
    p = (sb.shadow.size() > 0 && $urandom_range(0, 3) != 0) ?
        $urandom_range(0, sb.shadow.size() - 1) : $urandom_range(0, 15);
    send_req(kind, v, p[PW-1:0], g);
  endtask

  initial begin
    int k;
    int r;
    int calm;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: errors on empty, extreme values, fill past full, discards
    send_req(REQ_DEQ, '0, '0, 0);
    send_req(REQ_DIS, '0, 4'd0, 0);
    send_req(REQ_NOP, 32'hFFFF_FFFF, 4'hF, 0);
    send_req(REQ_ENQ, 32'h8000_0000, 4'hF, 0);
    send_req(REQ_ENQ, 32'h7FFF_FFFF, 4'h0, 0);
    send_req(REQ_ENQ, 32'hFFFF_FFFF, 4'h0, 1);
    for (k = 0; k < 14; k++) send_req(REQ_ENQ, 32'h1000 + k, 4'(k), 0);
    send_req(REQ_DIS, '0, 4'd15, 0);    // last element
    send_req(REQ_DIS, '0, 4'd7, 0);     // inner element
    send_req(REQ_DIS, '0, 4'd0, 0);     // front element
    send_req(REQ_DIS, '0, 4'd14, 0);    // past count: ignored
    send_req(REQ_NOP, '0, '0, 0);

    // Sender waits until every result is back
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);

    // Random: phases that lean toward filling or draining
    calm = 0;
    for (k = 0; k < 1850; k++) begin
      if (k % 200 == 0) calm = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if ((k / 100) % 2 == 0) begin
        if (r < 55) send_rand(REQ_ENQ, calm);
        else if (r < 70) send_rand(REQ_DEQ, calm);
        else if (r < 97) send_rand(REQ_DIS, calm);
        else send_rand(REQ_NOP, calm);
      end else begin
        if (r < 30) send_rand(REQ_ENQ, calm);
        else if (r < 60) send_rand(REQ_DEQ, calm);
        else if (r < 97) send_rand(REQ_DIS, calm);
        else send_rand(REQ_NOP, calm);
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Checked %0d results: %0d effective discards, %0d error responses.",
             sb.n_checked, sb.n_discard, sb.n_err);
    if (sb.n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
